// ===== design/sdrc_pkg.sv =====
// sdrc_pkg: shared types, constants and the crc16 byte fold for the sd block reader
// no dependencies; used by the channel interfaces and the top level
`default_nettype none

package sdrc_pkg;

  // largest block that the byte counter has to hold
  localparam int MAX_BLOCK = 4096;
  localparam int BLEFT_W   = $clog2(MAX_BLOCK + 1);

  // register widths and the configuration port
  localparam int BLEN_W    = 13;
  localparam int POLL_W    = 16;
  localparam int TOKEN_W   = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam int BYTE_W = 8;
  localparam int CRC_W  = 16;
  localparam int KIND_W = 2;

  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

  localparam logic [BLEN_W-1:0]  BLEN_RESET  = 13'd512;
  localparam logic [POLL_W-1:0]  POLL_RESET  = 16'd1000;
  localparam logic [TOKEN_W-1:0] TOKEN_RESET = 8'hFE;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_LENGTH = 2'd0,
    REG_POLL_LIMIT   = 2'd1,
    REG_START_TOKEN  = 2'd2
  } cfg_reg_t;

  typedef enum logic [0:0] {
    OP_START = 1'b0,
    OP_BYTE  = 1'b1
  } opcode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_DATA    = 2'd0,
    KIND_OK      = 2'd1,
    KIND_BAD     = 2'd2,
    KIND_TIMEOUT = 2'd3
  } kind_t;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_HUNT = 5'b00010,
    PH_DATA = 5'b00100,
    PH_CRCH = 5'b01000,
    PH_CRCL = 5'b10000
  } phase_t;

  // one byte folded msb first into the crc, eight shallow xor steps
  function automatic logic [CRC_W-1:0] crc16_fold(input logic [CRC_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    logic             fb;
    c = crc_in;
    for (int k = 0; k < BYTE_W; k++) begin
      fb = b[BYTE_W-1-k] ^ c[CRC_W-1];
      c  = {c[CRC_W-2:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/sdrc_in_if.sv =====
// sdrc_in_if: input channel, valid/ready with opcode and received spi byte
// depends on sdrc_pkg for field widths
`default_nettype none

interface sdrc_in_if;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [sdrc_pkg::BYTE_W-1:0]   rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== design/sdrc_out_if.sv =====
// sdrc_out_if: result channel, valid/ready with kind, data byte and crc values
// depends on sdrc_pkg for field widths
`default_nettype none

interface sdrc_out_if;
  logic                          valid;
  logic                          ready;
  logic [sdrc_pkg::KIND_W-1:0]   kind;
  logic [sdrc_pkg::BYTE_W-1:0]   data_byte;
  logic [sdrc_pkg::CRC_W-1:0]    crc_computed;
  logic [sdrc_pkg::CRC_W-1:0]    crc_from_card;

  modport source (output valid, output kind, output data_byte, output crc_computed,
                  output crc_from_card, input ready);
  modport sink   (input valid, input kind, input data_byte, input crc_computed,
                  input crc_from_card, output ready);
endinterface

`default_nettype wire

// ===== design/sd_read_block_crc16_check.sv =====
// sd_read_block_crc16_check: sd card spi data block receiver with crc16 check
// depends on sdrc_pkg, sdrc_in_if and sdrc_out_if
//
//   channel  | role   | transaction carries
//   ---------+--------+-----------------------------------------------------
//   in_ch    | sink   | opcode (start / spi byte), rx_byte
//   out_ch   | source | kind, data_byte, crc_computed, crc_from_card
//   cfg      | write  | cfg_write, cfg_index, cfg_data (no read-back)
//
// one input transaction per cycle while in_ch.ready is high; the phase, counters and crc fold sit in
// one short layer of logic between the state registers and the result register
// a result shows on out_ch the cycle after its input transaction
// in_ch.ready drops only while a result waits in the result register and
// out_ch.ready is low; the register empties and refills in the same cycle
// rst (synchronous) clears the phase, counters, crc and the result valid;
// the configuration registers return to 512, 1000 and 0xFE
`default_nettype none

module sd_read_block_crc16_check (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write,
  input  wire logic [sdrc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [sdrc_pkg::CFG_DAT_W-1:0]    cfg_data,
  sdrc_in_if.sink                                in_ch,
  sdrc_out_if.source                             out_ch
);

  // configuration registers
  logic [sdrc_pkg::BLEN_W-1:0]  block_length;
  logic [sdrc_pkg::POLL_W-1:0]  poll_limit;
  logic [sdrc_pkg::TOKEN_W-1:0] start_token;

  // block state
  sdrc_pkg::phase_t              phase, phase_next;
  logic [sdrc_pkg::POLL_W-1:0]   poll_count, poll_count_next;
  logic [sdrc_pkg::BLEFT_W-1:0]  bytes_left, bytes_left_next;
  logic [sdrc_pkg::CRC_W-1:0]    crc_accum, crc_accum_next;
  logic [sdrc_pkg::BYTE_W-1:0]   crc_high_byte, crc_high_byte_next;

  // result register
  logic                          res_valid;
  sdrc_pkg::kind_t               res_kind, res_kind_next;
  logic [sdrc_pkg::BYTE_W-1:0]   res_data, res_data_next;
  logic [sdrc_pkg::CRC_W-1:0]    res_crc_comp, res_crc_comp_next;
  logic [sdrc_pkg::CRC_W-1:0]    res_crc_rcv, res_crc_rcv_next;
  logic                          res_fire;

  logic                          accept;
  logic [sdrc_pkg::POLL_W-1:0]   poll_lim;
  logic [sdrc_pkg::POLL_W-1:0]   poll_inc;
  logic [sdrc_pkg::CRC_W-1:0]    crc_rcv;
  logic [sdrc_pkg::CRC_W-1:0]    crc_fold;
  logic [sdrc_pkg::BLEFT_W-1:0]  blen_sat;

  // result register frees up in the cycle it is taken
  assign in_ch.ready = !res_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign out_ch.valid         = res_valid;
  assign out_ch.kind          = res_kind;
  assign out_ch.data_byte     = res_data;
  assign out_ch.crc_computed  = res_crc_comp;
  assign out_ch.crc_from_card = res_crc_rcv;

  // configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      block_length <= sdrc_pkg::BLEN_RESET;
      poll_limit   <= sdrc_pkg::POLL_RESET;
      start_token  <= sdrc_pkg::TOKEN_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        sdrc_pkg::REG_BLOCK_LENGTH: block_length <= cfg_data[sdrc_pkg::BLEN_W-1:0];
        sdrc_pkg::REG_POLL_LIMIT:   poll_limit   <= cfg_data[sdrc_pkg::POLL_W-1:0];
        sdrc_pkg::REG_START_TOKEN:  start_token  <= cfg_data[sdrc_pkg::TOKEN_W-1:0];
        default: ;
      endcase
    end
  end

  // block length clamps to the counter range, a zero poll limit acts as one
  assign blen_sat = (32'(block_length) > 32'(sdrc_pkg::MAX_BLOCK))
                    ? sdrc_pkg::BLEFT_W'(sdrc_pkg::MAX_BLOCK)
                    : sdrc_pkg::BLEFT_W'(block_length);
  assign poll_lim = (poll_limit == '0) ? sdrc_pkg::POLL_W'(1) : poll_limit;
  assign poll_inc = poll_count + sdrc_pkg::POLL_W'(1);
  assign crc_fold = sdrc_pkg::crc16_fold(crc_accum, in_ch.rx_byte);
  assign crc_rcv  = {crc_high_byte, in_ch.rx_byte};

  always_comb begin
    phase_next         = phase;
    poll_count_next    = poll_count;
    bytes_left_next    = bytes_left;
    crc_accum_next     = crc_accum;
    crc_high_byte_next = crc_high_byte;
    res_fire           = 1'b0;
    res_kind_next      = sdrc_pkg::KIND_DATA;
    res_data_next      = '0;
    res_crc_comp_next  = '0;
    res_crc_rcv_next   = '0;

    if (in_ch.opcode == sdrc_pkg::OP_START) begin
      // start restarts from the token hunt, even mid-block
      phase_next         = sdrc_pkg::PH_HUNT;
      poll_count_next    = '0;
      crc_accum_next     = '0;
      crc_high_byte_next = '0;
      bytes_left_next    = blen_sat;
    end else begin
      unique case (phase)
        sdrc_pkg::PH_IDLE: ;  // stray bytes are ignored
        sdrc_pkg::PH_HUNT: begin
          if (in_ch.rx_byte == start_token) begin
            phase_next = (bytes_left == '0) ? sdrc_pkg::PH_CRCH : sdrc_pkg::PH_DATA;
          end else begin
            poll_count_next = poll_inc;
            if (poll_inc >= poll_lim) begin
              phase_next    = sdrc_pkg::PH_IDLE;
              res_fire      = 1'b1;
              res_kind_next = sdrc_pkg::KIND_TIMEOUT;
            end
          end
        end
        sdrc_pkg::PH_DATA: begin
          crc_accum_next = crc_fold;
          if (bytes_left != '0) begin
            bytes_left_next = bytes_left - sdrc_pkg::BLEFT_W'(1);
          end
          if (bytes_left <= sdrc_pkg::BLEFT_W'(1)) begin
            phase_next = sdrc_pkg::PH_CRCH;
          end
          res_fire      = 1'b1;
          res_kind_next = sdrc_pkg::KIND_DATA;
          res_data_next = in_ch.rx_byte;
        end
        sdrc_pkg::PH_CRCH: begin
          crc_high_byte_next = in_ch.rx_byte;
          phase_next         = sdrc_pkg::PH_CRCL;
        end
        sdrc_pkg::PH_CRCL: begin
          phase_next        = sdrc_pkg::PH_IDLE;
          res_fire          = 1'b1;
          res_kind_next     = (crc_rcv == crc_accum) ? sdrc_pkg::KIND_OK
                                                     : sdrc_pkg::KIND_BAD;
          res_crc_comp_next = crc_accum;
          res_crc_rcv_next  = crc_rcv;
        end
        default: phase_next = sdrc_pkg::PH_IDLE;
      endcase
    end
  end

  // state advances only on an accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= sdrc_pkg::PH_IDLE;
      poll_count    <= '0;
      bytes_left    <= '0;
      crc_accum     <= '0;
      crc_high_byte <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      poll_count    <= poll_count_next;
      bytes_left    <= bytes_left_next;
      crc_accum     <= crc_accum_next;
      crc_high_byte <= crc_high_byte_next;
    end
  end

  // result valid: set by a transaction that yields a result, cleared when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept && res_fire) begin
      res_valid <= 1'b1;
    end else if (out_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept && res_fire) begin
      res_kind     <= res_kind_next;
      res_data     <= res_data_next;
      res_crc_comp <= res_crc_comp_next;
      res_crc_rcv  <= res_crc_rcv_next;
    end
  end

endmodule

`default_nettype wire

// ===== test/tb_sd_read_block_crc16_check.sv =====
`timescale 1ns / 100ps
// tb_sd_read_block_crc16_check: self-checking bench for the sd spi block reader with crc16 check
// feeds start commands and card bytes, predicts every result and scores them in order
// depends on sdrc_pkg, sdrc_in_if, sdrc_out_if and sd_read_block_crc16_check

module tb_sd_read_block_crc16_check;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 5;
  localparam int RANDOM_ITEMS  = 640;
  localparam int RANDOM_PHASES = 8;
  // longest legal quiet stretch is a send gap plus a ready stall plus a register update
  localparam int STALL_LIMIT   = 2000;
  // a result shows in the cycle after its input transaction
  localparam int SETTLE_CYCLES = 4;

  typedef struct packed {
    sdrc_pkg::opcode_t             op;
    logic [sdrc_pkg::BYTE_W-1:0]   b;
  } spi_item_t;

  typedef struct packed {
    sdrc_pkg::kind_t               kind;
    logic [sdrc_pkg::BYTE_W-1:0]   data;
    logic [sdrc_pkg::CRC_W-1:0]    crc_calc;
    logic [sdrc_pkg::CRC_W-1:0]    crc_card;
  } card_result_t;

  logic                           clk;
  logic                           rst;
  logic                           cfg_write;
  logic [sdrc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [sdrc_pkg::CFG_DAT_W-1:0] cfg_data;

  sdrc_in_if  in_ch ();
  sdrc_out_if out_ch ();

  sd_read_block_crc16_check DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // bench copy of the three registers
  logic [sdrc_pkg::BLEN_W-1:0]  blen_reg;
  logic [sdrc_pkg::POLL_W-1:0]  poll_reg;
  logic [sdrc_pkg::TOKEN_W-1:0] token_reg;

  // predicted reader state
  sdrc_pkg::phase_t              rd_phase;
  logic [sdrc_pkg::POLL_W-1:0]   polls_seen;
  logic [sdrc_pkg::BLEFT_W-1:0]  bytes_to_go;
  logic [sdrc_pkg::CRC_W-1:0]    crc_run;
  logic [sdrc_pkg::BYTE_W-1:0]   crc_hi_seen;

  spi_item_t                    rx_feed[$];       // card bytes and starts waiting to be sent
  card_result_t                 card_out_due[$];  // results predicted but not yet seen
  logic [sdrc_pkg::BYTE_W-1:0]  payload[$];       // data bytes of the block being built
  spi_item_t                    on_bus;

  int fed_items;
  int accepted_items;
  int noise_items;
  int errors;
  int results_seen;
  int ok_seen;
  int bad_seen;
  int timeouts_seen;
  int settings_seen;
  int send_gap;
  int ready_gap;
  int stall_cycles;
  bit quiet_tail;

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // ccitt crc, byte at a time: xor the byte into the top, then shift out eight bits
  function automatic logic [sdrc_pkg::CRC_W-1:0] crc_ccitt_byte(
      logic [sdrc_pkg::CRC_W-1:0] crc, logic [sdrc_pkg::BYTE_W-1:0] b);
    logic [sdrc_pkg::CRC_W-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < sdrc_pkg::BYTE_W; i++) begin
      c = c[sdrc_pkg::CRC_W-1] ? ((c << 1) ^ sdrc_pkg::CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // block length is clamped to what the byte counter can hold
  function automatic int eff_len();
    return (blen_reg > sdrc_pkg::MAX_BLOCK) ? sdrc_pkg::MAX_BLOCK : int'(blen_reg);
  endfunction

  // a poll limit of zero acts like one
  function automatic int eff_lim();
    return (poll_reg == '0) ? 1 : int'(poll_reg);
  endfunction

  // advance the predicted reader by one accepted transaction
  task automatic track_card_read(spi_item_t it);
    card_result_t               r;
    logic [sdrc_pkg::CRC_W-1:0] card_crc;
    r = '0;
    if (it.op == sdrc_pkg::OP_START) begin
      // start always rearms, even in the middle of a block
      rd_phase    = sdrc_pkg::PH_HUNT;
      polls_seen  = '0;
      crc_run     = '0;
      crc_hi_seen = '0;
      bytes_to_go = sdrc_pkg::BLEFT_W'(eff_len());
    end else begin
      case (rd_phase)
        sdrc_pkg::PH_HUNT: begin
          if (it.b == token_reg) begin
            // empty block goes straight to the crc bytes
            rd_phase = (bytes_to_go == '0) ? sdrc_pkg::PH_CRCH : sdrc_pkg::PH_DATA;
          end else begin
            polls_seen = polls_seen + 1'b1;
            if (polls_seen >= eff_lim()) begin
              rd_phase = sdrc_pkg::PH_IDLE;
              r.kind   = sdrc_pkg::KIND_TIMEOUT;
              card_out_due.push_back(r);
            end
          end
        end
        sdrc_pkg::PH_DATA: begin
          crc_run = crc_ccitt_byte(crc_run, it.b);
          if (bytes_to_go != '0) begin
            bytes_to_go = bytes_to_go - 1'b1;
          end
          if (bytes_to_go == '0) begin
            rd_phase = sdrc_pkg::PH_CRCH;
          end
          r.kind = sdrc_pkg::KIND_DATA;
          r.data = it.b;
          card_out_due.push_back(r);
        end
        sdrc_pkg::PH_CRCH: begin
          // high crc byte is only held
          crc_hi_seen = it.b;
          rd_phase    = sdrc_pkg::PH_CRCL;
        end
        sdrc_pkg::PH_CRCL: begin
          card_crc   = {crc_hi_seen, it.b};
          rd_phase   = sdrc_pkg::PH_IDLE;
          if (card_crc == crc_run) begin
            r.kind = sdrc_pkg::KIND_OK;
          end else begin
            r.kind = sdrc_pkg::KIND_BAD;
          end
          r.crc_calc = crc_run;
          r.crc_card = card_crc;
          card_out_due.push_back(r);
        end
        default: begin
          // bytes while idle are dropped
          rd_phase = sdrc_pkg::PH_IDLE;
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------

  task automatic feed(sdrc_pkg::opcode_t op, logic [sdrc_pkg::BYTE_W-1:0] b);
    spi_item_t it;
    it.op = op;
    it.b  = b;
    rx_feed.push_back(it);
    fed_items++;
  endtask

  // any byte that is not the current token
  function automatic logic [sdrc_pkg::BYTE_W-1:0] non_token();
    logic [sdrc_pkg::BYTE_W-1:0] v;
    v = sdrc_pkg::BYTE_W'($urandom);
    if (v == token_reg) begin
      v = v + 1'b1;
    end
    return v;
  endfunction

  task automatic random_payload(int n);
    payload.delete();
    repeat (n) payload.push_back(sdrc_pkg::BYTE_W'($urandom));
  endtask

  task automatic set_payload(logic [sdrc_pkg::BYTE_W-1:0] a, logic [sdrc_pkg::BYTE_W-1:0] b);
    payload.delete();
    payload.push_back(a);
    payload.push_back(b);
  endtask

  // token, payload and the card crc, high byte first; corrupt flips crc bits
  task automatic feed_block(bit corrupt);
    logic [sdrc_pkg::CRC_W-1:0] c;
    c = '0;
    feed(sdrc_pkg::OP_BYTE, token_reg);
    foreach (payload[i]) begin
      feed(sdrc_pkg::OP_BYTE, payload[i]);
      c = crc_ccitt_byte(c, payload[i]);
    end
    if (corrupt) begin
      c = c ^ sdrc_pkg::CRC_W'($urandom_range(1, 16'hFFFF));
    end
    feed(sdrc_pkg::OP_BYTE, c[15:8]);
    feed(sdrc_pkg::OP_BYTE, c[7:0]);
  endtask

  // register write, one cycle of cfg_write; the bench copy follows along
  task automatic write_reg(sdrc_pkg::cfg_reg_t idx, logic [sdrc_pkg::CFG_DAT_W-1:0] v);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    case (idx)
      sdrc_pkg::REG_BLOCK_LENGTH: blen_reg  = v[sdrc_pkg::BLEN_W-1:0];
      sdrc_pkg::REG_POLL_LIMIT:   poll_reg  = v[sdrc_pkg::POLL_W-1:0];
      sdrc_pkg::REG_START_TOKEN:  token_reg = v[sdrc_pkg::TOKEN_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_regs(int blen, int poll, int token);
    write_reg(sdrc_pkg::REG_BLOCK_LENGTH, sdrc_pkg::CFG_DAT_W'(blen));
    write_reg(sdrc_pkg::REG_POLL_LIMIT, sdrc_pkg::CFG_DAT_W'(poll));
    write_reg(sdrc_pkg::REG_START_TOKEN, sdrc_pkg::CFG_DAT_W'(token));
    settings_seen++;
  endtask

  // hold the sender until every transaction is taken and every result is back
  task automatic drain();
    while (accepted_items != fed_items || card_out_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly well-formed reads with random content, plus timeouts, cut-off reads and noise
  task automatic random_phase(int quota);
    int                base;
    int                r;
    int                lim;
    int                k;
    sdrc_pkg::opcode_t op_pick;
    base = fed_items - noise_items;
    while (fed_items - noise_items - base < quota) begin
      lim = eff_lim();
      r   = $urandom_range(0, 99);
      if (r < 60) begin
        feed(sdrc_pkg::OP_START, sdrc_pkg::BYTE_W'($urandom));
        repeat ($urandom_range(0, (lim > 6) ? 5 : lim - 1)) feed(sdrc_pkg::OP_BYTE, non_token());
        random_payload(eff_len());
        feed_block($urandom_range(0, 3) == 0);
      end else if (r < 72 && lim <= 16) begin
        feed(sdrc_pkg::OP_START, sdrc_pkg::BYTE_W'($urandom));
        repeat (lim) feed(sdrc_pkg::OP_BYTE, non_token());
      end else if (r < 86) begin
        // read that the next start cuts short, in the hunt or in the payload
        feed(sdrc_pkg::OP_START, sdrc_pkg::BYTE_W'($urandom));
        if ($urandom_range(0, 1) == 0) begin
          repeat ($urandom_range(0, (lim > 6) ? 5 : lim - 1)) begin
            feed(sdrc_pkg::OP_BYTE, non_token());
          end
        end else begin
          feed(sdrc_pkg::OP_BYTE, token_reg);
          repeat ($urandom_range(0, eff_len())) begin
            feed(sdrc_pkg::OP_BYTE, sdrc_pkg::BYTE_W'($urandom));
          end
        end
      end else begin
        k = fed_items;
        repeat ($urandom_range(1, 4)) begin
          op_pick = sdrc_pkg::OP_BYTE;
          if ($urandom_range(0, 3) == 0) begin
            op_pick = sdrc_pkg::OP_START;
          end
          feed(op_pick, sdrc_pkg::BYTE_W'($urandom));
        end
        noise_items += fed_items - k;
      end
    end
  endtask

  // check one field; 4-state compare so an x on the port fails
  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: pops the feed queue, predicts on every accepted transaction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_spi
    spi_item_t nxt;
    if (rst) begin
      in_ch.valid   <= 1'b0;
      in_ch.opcode  <= sdrc_pkg::OP_START;
      in_ch.rx_byte <= '0;
      rd_phase      = sdrc_pkg::PH_IDLE;
      polls_seen    = '0;
      bytes_to_go   = '0;
      crc_run       = '0;
      crc_hi_seen   = '0;
      send_gap      = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        track_card_read(on_bus);
        accepted_items++;
      end
      // the bus may change only once the current transaction is gone
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (rx_feed.size() > 0) begin
          nxt            = rx_feed.pop_front();
          on_bus         = nxt;
          in_ch.valid   <= 1'b1;
          in_ch.opcode  <= nxt.op;
          in_ch.rx_byte <= nxt.b;
          // a burst of idle cycles starts after this transaction
          if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(1, 18);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: scores results in order, stalls ready in bursts
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : score_results
    card_result_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
      ready_gap    = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (card_out_due.size() == 0) begin
          $display("%0t: result with nothing expected, expected none, actual kind %0d data %0h",
                   $time, out_ch.kind, out_ch.data_byte);
          errors++;
        end else begin
          want = card_out_due.pop_front();
          check_field("kind", want.kind, out_ch.kind);
          check_field("data_byte", want.data, out_ch.data_byte);
          check_field("crc_computed", want.crc_calc, out_ch.crc_computed);
          check_field("crc_from_card", want.crc_card, out_ch.crc_from_card);
          case (want.kind)
            sdrc_pkg::KIND_OK:      ok_seen++;
            sdrc_pkg::KIND_BAD:     bad_seen++;
            sdrc_pkg::KIND_TIMEOUT: timeouts_seen++;
            default: ;
          endcase
        end
      end
      if (ready_gap > 0) begin
        ready_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (!quiet_tail && $urandom_range(0, 11) == 0) begin
          ready_gap = $urandom_range(1, 18);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long with no transaction on either channel
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results still expected",
               $time, STALL_LIMIT, card_out_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int r;
    int blen_pick;
    int poll_pick;

    // every input known from time zero
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = sdrc_pkg::REG_BLOCK_LENGTH;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.opcode  = sdrc_pkg::OP_START;
    in_ch.rx_byte = '0;
    out_ch.ready  = 1'b0;
    blen_reg      = sdrc_pkg::BLEN_RESET;
    poll_reg      = sdrc_pkg::POLL_RESET;
    token_reg     = sdrc_pkg::TOKEN_RESET;
    quiet_tail    = 1'b0;
    stall_cycles  = 0;
    settings_seen = 1;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // reset values: bytes while idle are dropped, then one full 512-byte read on 0xfe
    feed(sdrc_pkg::OP_BYTE, 8'h00);
    feed(sdrc_pkg::OP_BYTE, 8'hFF);
    feed(sdrc_pkg::OP_START, 8'hFF);
    feed(sdrc_pkg::OP_BYTE, 8'h00);
    feed(sdrc_pkg::OP_BYTE, 8'hFD);
    random_payload(eff_len());
    feed_block(1'b0);
    drain();

    // short blocks: good crc, bad crc, timeout, restart mid-payload, idle byte
    set_regs(2, 3, 8'hA5);
    feed(sdrc_pkg::OP_START, 8'h00);
    feed(sdrc_pkg::OP_BYTE, 8'h00);
    feed(sdrc_pkg::OP_BYTE, 8'hFF);
    set_payload(8'h00, 8'hFF);
    feed_block(1'b0);
    feed(sdrc_pkg::OP_START, 8'hFF);
    set_payload(8'h80, 8'h01);
    feed_block(1'b1);
    feed(sdrc_pkg::OP_START, 8'h00);
    feed(sdrc_pkg::OP_BYTE, 8'h5A);
    feed(sdrc_pkg::OP_BYTE, 8'h00);
    feed(sdrc_pkg::OP_BYTE, 8'hFF);
    feed(sdrc_pkg::OP_START, 8'h00);
    feed(sdrc_pkg::OP_BYTE, 8'hA5);
    feed(sdrc_pkg::OP_BYTE, 8'h12);
    feed(sdrc_pkg::OP_START, 8'h00);
    set_payload(8'h34, 8'h56);
    feed_block(1'b0);
    feed(sdrc_pkg::OP_BYTE, 8'h77);
    drain();

    // zero-length block, zero poll limit, token 0x00
    set_regs(0, 0, 8'h00);
    payload.delete();
    feed(sdrc_pkg::OP_START, 8'h00);
    feed_block(1'b0);
    feed(sdrc_pkg::OP_START, 8'h00);
    feed(sdrc_pkg::OP_BYTE, 8'h01);
    feed(sdrc_pkg::OP_START, 8'h00);
    feed_block(1'b1);
    drain();

    // oversize length, widest poll limit, token 0xff; a new start cuts the long read short
    set_regs(8191, 16'hFFFF, 8'hFF);
    feed(sdrc_pkg::OP_START, 8'h00);
    feed(sdrc_pkg::OP_BYTE, 8'h00);
    feed(sdrc_pkg::OP_BYTE, token_reg);
    random_payload(24);
    foreach (payload[i]) feed(sdrc_pkg::OP_BYTE, payload[i]);
    feed(sdrc_pkg::OP_START, 8'h00);
    drain();

    // random settings, one drained phase each; the last phase runs with no idling
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == RANDOM_PHASES - 1) begin
        quiet_tail = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 10) begin
        blen_pick = 0;
      end else if (r < 80) begin
        blen_pick = $urandom_range(1, 6);
      end else begin
        blen_pick = $urandom_range(7, 40);
      end
      r = $urandom_range(0, 99);
      if (r < 10) begin
        poll_pick = 0;
      end else if (r < 85) begin
        poll_pick = $urandom_range(1, 6);
      end else if (r < 95) begin
        poll_pick = $urandom_range(7, 16);
      end else begin
        poll_pick = 16'hFFFF;
      end
      set_regs(blen_pick, poll_pick, $urandom_range(0, 255));
      random_phase(RANDOM_ITEMS / RANDOM_PHASES);
      drain();
    end

    $display("run covered %0d spi transactions and %0d results over %0d register settings",
             accepted_items, results_seen, settings_seen);
    $display("final statuses seen: %0d crc ok, %0d crc mismatch, %0d token timeouts",
             ok_seen, bad_seen, timeouts_seen);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sd_read_block_crc16_check.f =====
design/sdrc_pkg.sv
design/sdrc_in_if.sv
design/sdrc_out_if.sv
design/sd_read_block_crc16_check.sv
test/tb_sd_read_block_crc16_check.sv
